@@ rtl/pacd_pkg.sv @@
// Package: shared types, register defaults and arithmetic constants of the precip area detector.
`default_nettype none

package pacd_pkg;

    // Valid range bins: a bin at or beyond this index is never counted
    localparam int NUM_RANGE_BINS = 230;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_Z_THRESHOLD   = 3'd0,
        CFG_MISSING_CODE  = 3'd1,
        CFG_AREA_THRESH   = 3'd2,
        CFG_BIN_AREA_UNIT = 3'd3,
        CFG_AUTO_PRECIP   = 3'd4,
        CFG_HOLD_MINUTES  = 3'd5
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Register reset values
    localparam logic [7:0]  Z_THRESHOLD_RST   = 8'd106;
    localparam logic [7:0]  MISSING_CODE_RST  = 8'd0;
    localparam logic [16:0] AREA_THRESH_RST   = 17'd80;
    localparam logic [23:0] BIN_AREA_UNIT_RST = 24'd57194;
    localparam logic        AUTO_PRECIP_RST   = 1'b1;
    localparam logic [10:0] HOLD_MINUTES_RST  = 11'd60;

    localparam logic [16:0] SEC_PER_MIN = 17'd60;

    // Area = floor(sum*unit / (100 * 2^16)) = floor((sum*unit >> 18) / 25).
    // Divide by 25 in two halves, each with a reciprocal multiply.
    localparam int          AREA_SHIFT = 18;
    localparam int          PROD_W     = 56;
    localparam int          SPLIT_W    = 19;
    localparam logic [4:0]  DIV_BY     = 5'd25;
    localparam logic [19:0] DIV_M_HI   = 20'd671089;     // ceil(2^24 / 25)
    localparam int          DIV_S_HI   = 24;
    localparam logic [24:0] DIV_M_LO   = 25'd21474837;   // ceil(2^29 / 25)
    localparam int          DIV_S_LO   = 29;
    localparam int          QUOT_W     = 34;

    typedef struct packed {
        logic [7:0]  z_threshold_scaled;
        logic [7:0]  missing_code;
        logic [16:0] area_threshold_km2;
        logic [23:0] bin_area_unit;
        logic        auto_precip_mode;
        logic [10:0] clear_air_hold_minutes;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  reflectivity;
        logic [9:0]  range_index;
        logic        scan_end;
        logic [31:0] scan_time;
    } in_item_t;

    typedef struct packed {
        logic [31:0] area_km2;
        logic        area_over_threshold;
        logic        category;
        logic [31:0] clear_air_time;
        logic [31:0] last_precip_time;
        logic [31:0] hold_seconds_left;
    } out_item_t;

    // Final weighted sum of one scan
    typedef struct packed {
        logic [31:0] weighted_sum;
        logic [31:0] scan_time;
    } scan_sum_t;

    // Unsaturated area quotient of one scan
    typedef struct packed {
        logic [QUOT_W-1:0] area_quot;
        logic [31:0]       scan_time;
    } area_quot_t;

endpackage

`default_nettype wire

@@ rtl/precip_area_category_detector_core.sv @@
// Top level: configuration registers and the accumulate, area and hold stages.
//
// Usage: stream reflectivity bins on the s_ channel (valid/ready), one transaction
// per bin; the bin with scan_end set closes the scan. Only that bin produces a
// result transaction on the m_ channel: area in km2, threshold flag, category and
// the clear-air / last-precip times. Other bins produce nothing.
// Throughput: one bin per cycle, including back-to-back scan ends, while m_ready takes the results.
// The result passes through the input register, accumulator, multiplier, three
// divide-by-25 stages and the result register.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high; write
// only while no scan is in flight.
// Reset (aresetn low, synchronous): registers return to defaults, the running sum
// and the stored times clear, and all pipeline stages empty.
// Stall: when m_ready is low the result register holds; stages behind it fill their
// empty slots and s_ready drops once all are full. Non-final bins keep draining
// into the accumulator while a result waits.
`default_nettype none

module precip_area_category_detector_core #(
    parameter int NUM_RANGE_BINS = pacd_pkg::NUM_RANGE_BINS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [pacd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pacd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire pacd_pkg::in_item_t                   s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output pacd_pkg::out_item_t                       m_data
);

    pacd_pkg::cfg_t       cfg_reg;
    pacd_pkg::cfg_t       cfg_next;
    logic                 sum_valid;
    logic                 sum_ready;
    pacd_pkg::scan_sum_t  sum_data;
    logic                 quot_valid;
    logic                 quot_ready;
    pacd_pkg::area_quot_t quot_data;

    // Decode configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (pacd_pkg::cfg_index_t'(cfg_index))
                pacd_pkg::CFG_Z_THRESHOLD: begin
                    cfg_next.z_threshold_scaled = cfg_wdata[7:0];
                end
                pacd_pkg::CFG_MISSING_CODE: begin
                    cfg_next.missing_code = cfg_wdata[7:0];
                end
                pacd_pkg::CFG_AREA_THRESH: begin
                    cfg_next.area_threshold_km2 = cfg_wdata[16:0];
                end
                pacd_pkg::CFG_BIN_AREA_UNIT: begin
                    cfg_next.bin_area_unit = cfg_wdata[23:0];
                end
                pacd_pkg::CFG_AUTO_PRECIP: begin
                    cfg_next.auto_precip_mode = cfg_wdata[0];
                end
                pacd_pkg::CFG_HOLD_MINUTES: begin
                    cfg_next.clear_air_hold_minutes = cfg_wdata[10:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.z_threshold_scaled     <= pacd_pkg::Z_THRESHOLD_RST;
            cfg_reg.missing_code           <= pacd_pkg::MISSING_CODE_RST;
            cfg_reg.area_threshold_km2     <= pacd_pkg::AREA_THRESH_RST;
            cfg_reg.bin_area_unit          <= pacd_pkg::BIN_AREA_UNIT_RST;
            cfg_reg.auto_precip_mode       <= pacd_pkg::AUTO_PRECIP_RST;
            cfg_reg.clear_air_hold_minutes <= pacd_pkg::HOLD_MINUTES_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pacd_accum #(
        .NUM_RANGE_BINS (NUM_RANGE_BINS)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum_data  (sum_data)
    );

    pacd_area u_area (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (quot_valid),
        .out_ready (quot_ready),
        .out_data  (quot_data)
    );

    pacd_hold u_hold (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (quot_valid),
        .in_ready (quot_ready),
        .in_data  (quot_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/pacd_accum.sv @@
// Input register and weighted bin accumulator; emits the final sum at scan end.
`default_nettype none

module pacd_accum #(
    parameter int NUM_RANGE_BINS = pacd_pkg::NUM_RANGE_BINS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire pacd_pkg::cfg_t        cfg,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire pacd_pkg::in_item_t    s_data,
    output logic                       sum_valid,
    input  wire logic                  sum_ready,
    output pacd_pkg::scan_sum_t        sum_data
);

    logic                a_valid_reg;
    logic                a_valid_next;
    pacd_pkg::in_item_t  a_data_reg;
    logic                b_valid_reg;
    logic                b_valid_next;
    pacd_pkg::scan_sum_t b_data_reg;
    pacd_pkg::scan_sum_t b_data_next;
    logic [31:0]         sum_reg;
    logic [31:0]         sum_next;

    logic        b_en;
    logic        a_move;
    logic        counted;
    logic [10:0] weight;
    logic [32:0] sum_wide;
    logic [31:0] sum_sat;

    // Stage enables: a non-final bin always drains into the accumulator
    assign b_en    = !b_valid_reg || sum_ready;
    assign a_move  = a_valid_reg && (!a_data_reg.scan_end || b_en);
    assign s_ready = !a_valid_reg || a_move;

    // Qualify the bin and form its ring weight 2*range+1
    assign counted = ({1'b0, a_data_reg.range_index} < 11'(NUM_RANGE_BINS))
                  && (a_data_reg.reflectivity != cfg.missing_code)
                  && (a_data_reg.reflectivity >= cfg.z_threshold_scaled);
    assign weight   = {a_data_reg.range_index, 1'b1};
    assign sum_wide = {1'b0, sum_reg} + (counted ? 33'(weight) : 33'd0);
    assign sum_sat  = sum_wide[32] ? '1 : sum_wide[31:0];

    // Advance the sum, handing it off and clearing at scan end
    always_comb begin
        sum_next     = sum_reg;
        b_valid_next = b_valid_reg;
        b_data_next  = b_data_reg;
        if (b_en) begin
            b_valid_next = 1'b0;
        end
        if (a_move) begin
            if (a_data_reg.scan_end) begin
                sum_next                 = '0;
                b_valid_next             = 1'b1;
                b_data_next.weighted_sum = sum_sat;
                b_data_next.scan_time    = a_data_reg.scan_time;
            end else begin
                sum_next = sum_sat;
            end
        end
        a_valid_next = a_valid_reg;
        if (s_valid && s_ready) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            sum_reg     <= '0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            sum_reg     <= sum_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_data_reg <= s_data;
        end
        b_data_reg <= b_data_next;
    end

    assign sum_valid = b_valid_reg;
    assign sum_data  = b_data_reg;

endmodule

`default_nettype wire

@@ rtl/pacd_area.sv @@
// Area pipeline: sum times bin area unit, then divide by 100 * 2^16.
`default_nettype none

module pacd_area (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire pacd_pkg::cfg_t        cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pacd_pkg::scan_sum_t   in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output pacd_pkg::area_quot_t       out_data
);

    localparam int XW = pacd_pkg::PROD_W - pacd_pkg::AREA_SHIFT;
    localparam int HW = XW - pacd_pkg::SPLIT_W;
    localparam int QHW = 15;
    localparam int YW = 24;
    localparam int QLW = 20;

    // Stage valids
    logic v_c_reg, v_d1_reg, v_d2_reg, v_d3_reg;
    logic en_c, en_d1, en_d2, en_d3;

    // Stage payloads
    logic [pacd_pkg::PROD_W-1:0] prod_c_reg;
    logic [31:0]                 t_c_reg;
    logic [HW-1:0]               xh_d1_reg;
    logic [pacd_pkg::SPLIT_W-1:0] xl_d1_reg;
    logic [QHW-1:0]              qh_d1_reg;
    logic [31:0]                 t_d1_reg;
    logic [QHW-1:0]              qh_d2_reg;
    logic [YW-1:0]               y_d2_reg;
    logic [31:0]                 t_d2_reg;
    pacd_pkg::area_quot_t        d3_reg;

    logic [pacd_pkg::PROD_W-1:0] prod;
    logic [XW-1:0]               x;
    logic [HW+19:0]              qh_prod;
    logic [HW-1:0]               rh;
    logic [YW+24:0]              ql_prod;
    logic [QLW-1:0]              ql;

    // Collapse bubbles: a stage loads when empty or when it drains
    assign en_d3    = !v_d3_reg || out_ready;
    assign en_d2    = !v_d2_reg || en_d3;
    assign en_d1    = !v_d1_reg || en_d2;
    assign en_c     = !v_c_reg  || en_d1;
    assign in_ready = en_c;

    // Multiply sum by unit
    assign prod = pacd_pkg::PROD_W'(in_data.weighted_sum)
                * pacd_pkg::PROD_W'(cfg.bin_area_unit);

    // Divide the upper half by 25
    assign x       = prod_c_reg[pacd_pkg::PROD_W-1:pacd_pkg::AREA_SHIFT];
    assign qh_prod = (HW + 20)'(x[XW-1:pacd_pkg::SPLIT_W]) * (HW + 20)'(pacd_pkg::DIV_M_HI);

    // Fold the upper remainder into the lower half
    assign rh = xh_d1_reg - HW'(qh_d1_reg) * HW'(pacd_pkg::DIV_BY);

    // Divide the lower half by 25 and combine
    assign ql_prod = (YW + 25)'(y_d2_reg) * (YW + 25)'(pacd_pkg::DIV_M_LO);
    assign ql      = ql_prod[pacd_pkg::DIV_S_LO +: QLW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_c_reg  <= 1'b0;
            v_d1_reg <= 1'b0;
            v_d2_reg <= 1'b0;
            v_d3_reg <= 1'b0;
        end else begin
            if (en_c) begin
                v_c_reg <= in_valid;
            end
            if (en_d1) begin
                v_d1_reg <= v_c_reg;
            end
            if (en_d2) begin
                v_d2_reg <= v_d1_reg;
            end
            if (en_d3) begin
                v_d3_reg <= v_d2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c) begin
            prod_c_reg <= prod;
            t_c_reg    <= in_data.scan_time;
        end
        if (en_d1) begin
            xh_d1_reg <= x[XW-1:pacd_pkg::SPLIT_W];
            xl_d1_reg <= x[pacd_pkg::SPLIT_W-1:0];
            qh_d1_reg <= qh_prod[pacd_pkg::DIV_S_HI +: QHW];
            t_d1_reg  <= t_c_reg;
        end
        if (en_d2) begin
            qh_d2_reg <= qh_d1_reg;
            y_d2_reg  <= {rh[4:0], xl_d1_reg};
            t_d2_reg  <= t_d1_reg;
        end
        if (en_d3) begin
            d3_reg.area_quot <= {qh_d2_reg, pacd_pkg::SPLIT_W'(0)}
                              + pacd_pkg::QUOT_W'(ql);
            d3_reg.scan_time <= t_d2_reg;
        end
    end

    assign out_valid = v_d3_reg;
    assign out_data  = d3_reg;

endmodule

`default_nettype wire

@@ rtl/pacd_hold.sv @@
// Result stage: area threshold, clear-air hold time update and output register.
`default_nettype none

module pacd_hold (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire pacd_pkg::cfg_t        cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pacd_pkg::area_quot_t  in_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output pacd_pkg::out_item_t        m_data
);

    logic                m_valid_reg;
    pacd_pkg::out_item_t m_data_reg;
    pacd_pkg::out_item_t m_data_next;
    logic [31:0]         cla_reg;
    logic [31:0]         cla_next;
    logic [31:0]         lpt_reg;
    logic [31:0]         lpt_next;
    logic [10:0]         prev_hold_reg;
    logic [10:0]         prev_hold_next;

    logic        load;
    logic        over;
    logic [31:0] t;
    logic [16:0] hold_sec;
    logic [32:0] t_plus_hold;
    logic [31:0] t_plus_hold_sat;
    logic [31:0] cla_tmp;

    assign in_ready = !m_valid_reg || m_ready;
    assign load     = in_valid && in_ready;

    assign t               = in_data.scan_time;
    assign over            = in_data.area_quot >= pacd_pkg::QUOT_W'(cfg.area_threshold_km2);
    assign hold_sec        = 17'(cfg.clear_air_hold_minutes) * pacd_pkg::SEC_PER_MIN;
    assign t_plus_hold     = {1'b0, t} + 33'(hold_sec);
    assign t_plus_hold_sat = t_plus_hold[32] ? '1 : t_plus_hold[31:0];

    // Update clear-air and last-precip times
    always_comb begin
        cla_tmp        = cla_reg;
        cla_next       = cla_reg;
        lpt_next       = lpt_reg;
        prev_hold_next = prev_hold_reg;
        if (over) begin
            cla_next = cfg.auto_precip_mode ? t_plus_hold_sat : t;
            lpt_next = t;
        end else begin
            if (cfg.auto_precip_mode
                && ((prev_hold_reg != cfg.clear_air_hold_minutes)
                    || ({1'b0, cla_reg} > t_plus_hold))
                && (cla_reg > t)) begin
                cla_tmp = t_plus_hold_sat;
            end
            prev_hold_next = cfg.clear_air_hold_minutes;
            if ((cla_tmp < t) || !cfg.auto_precip_mode) begin
                cla_tmp = t;
            end
            cla_next = cla_tmp;
        end
    end

    // Form the result transaction
    always_comb begin
        m_data_next.area_km2            = (in_data.area_quot[pacd_pkg::QUOT_W-1:32] != '0)
                                        ? '1 : in_data.area_quot[31:0];
        m_data_next.area_over_threshold = over;
        m_data_next.category            = (t < cla_next) ? 1'b1 : over;
        m_data_next.clear_air_time      = cla_next;
        m_data_next.last_precip_time    = lpt_next;
        m_data_next.hold_seconds_left   = cla_next - t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            cla_reg       <= '0;
            lpt_reg       <= '0;
            prev_hold_reg <= '0;
        end else begin
            if (load) begin
                m_valid_reg   <= 1'b1;
                cla_reg       <= cla_next;
                lpt_reg       <= lpt_next;
                prev_hold_reg <= prev_hold_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ dv/pacd_checker.sv @@
`timescale 1ns / 100ps
// Checker: watches the bin and report channels, predicts each scan report and compares.
module pacd_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [pacd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pacd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_valid,
    input  wire logic                             s_ready,
    input  pacd_pkg::in_item_t                    s_data,
    input  wire logic                             m_valid,
    input  wire logic                             m_ready,
    input  pacd_pkg::out_item_t                   m_data,
    output int                                    mismatch_count,
    output int                                    results_checked,
    output int                                    results_pending
);
    import pacd_pkg::*;

    // Area divisor: 100 hundredths times 2^16 fraction scale
    localparam logic [63:0] HUNDREDTHS_Q16 = 64'd6553600;
    localparam logic [63:0] SECONDS_PER_MINUTE = 64'd60;
    localparam logic [63:0] U32_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam int MAX_PRINTED = 50;

    cfg_t        regs;
    logic [31:0] weighted_sum;
    logic [31:0] clear_air_at;
    logic [31:0] last_precip_at;
    logic [10:0] prior_hold_min;
    out_item_t   expected_scan_reports[$];

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v > U32_MAX) ? U32_MAX[31:0] : v[31:0];
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns: MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input int scan_no,
                                 input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("report %0d %s: got 0x%0h, expected 0x%0h",
                                      scan_no, name, got, want));
    endtask

    // Add one bin to the running sum; on the last bin of a scan, form the report
    task automatic accumulate_bin(input in_item_t item);
        logic [63:0] sum_ext;
        logic [63:0] prod;
        logic [63:0] thr;
        logic [63:0] hold;
        logic [63:0] t;
        logic        over;
        out_item_t   rpt;
        if (item.range_index < NUM_RANGE_BINS && item.reflectivity != regs.missing_code &&
            item.reflectivity >= regs.z_threshold_scaled) begin
            sum_ext = weighted_sum + 2 * item.range_index + 1;
            weighted_sum = sat32(sum_ext);
        end
        if (item.scan_end) begin
            prod = weighted_sum * regs.bin_area_unit;
            thr  = regs.area_threshold_km2 * HUNDREDTHS_Q16;
            over = (prod >= thr);
            hold = regs.clear_air_hold_minutes * SECONDS_PER_MINUTE;
            t    = item.scan_time;
            if (over) begin
                clear_air_at   = sat32(t + (regs.auto_precip_mode ? hold : 64'd0));
                last_precip_at = item.scan_time;
            end else begin
                // Restart the hold when its length changed or it would end too late
                if (regs.auto_precip_mode &&
                    (prior_hold_min != regs.clear_air_hold_minutes || clear_air_at > t + hold) &&
                    clear_air_at > t)
                    clear_air_at = sat32(t + hold);
                prior_hold_min = regs.clear_air_hold_minutes;
                if (clear_air_at < t || !regs.auto_precip_mode)
                    clear_air_at = item.scan_time;
            end
            rpt.area_km2            = sat32(prod / HUNDREDTHS_Q16);
            rpt.area_over_threshold = over;
            rpt.category            = (t < clear_air_at) || over;
            rpt.clear_air_time      = clear_air_at;
            rpt.last_precip_time    = last_precip_at;
            rpt.hold_seconds_left   = clear_air_at - item.scan_time;
            expected_scan_reports.push_back(rpt);
            weighted_sum = '0;
        end
    endtask

    // Compare one report transaction with the oldest prediction
    task automatic check_scan_report(input out_item_t got);
        out_item_t want;
        if (expected_scan_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected report, area_km2 0x%0h", got.area_km2));
        end else begin
            want = expected_scan_reports.pop_front();
            compare_field("area_km2", results_checked, got.area_km2, want.area_km2);
            compare_field("area_over_threshold", results_checked,
                          got.area_over_threshold, want.area_over_threshold);
            compare_field("category", results_checked, got.category, want.category);
            compare_field("clear_air_time", results_checked,
                          got.clear_air_time, want.clear_air_time);
            compare_field("last_precip_time", results_checked,
                          got.last_precip_time, want.last_precip_time);
            compare_field("hold_seconds_left", results_checked,
                          got.hold_seconds_left, want.hold_seconds_left);
            results_checked++;
        end
    endtask

    // Track registers, predict on accepted bins, check accepted reports
    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.z_threshold_scaled     = Z_THRESHOLD_RST;
            regs.missing_code           = MISSING_CODE_RST;
            regs.area_threshold_km2     = AREA_THRESH_RST;
            regs.bin_area_unit          = BIN_AREA_UNIT_RST;
            regs.auto_precip_mode       = AUTO_PRECIP_RST;
            regs.clear_air_hold_minutes = HOLD_MINUTES_RST;
            weighted_sum    = '0;
            clear_air_at    = '0;
            last_precip_at  = '0;
            prior_hold_min  = '0;
            mismatch_count  = 0;
            results_checked = 0;
            expected_scan_reports.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_Z_THRESHOLD:   regs.z_threshold_scaled     = cfg_wdata[7:0];
                    CFG_MISSING_CODE:  regs.missing_code           = cfg_wdata[7:0];
                    CFG_AREA_THRESH:   regs.area_threshold_km2     = cfg_wdata[16:0];
                    CFG_BIN_AREA_UNIT: regs.bin_area_unit          = cfg_wdata[23:0];
                    CFG_AUTO_PRECIP:   regs.auto_precip_mode       = cfg_wdata[0];
                    CFG_HOLD_MINUTES:  regs.clear_air_hold_minutes = cfg_wdata[10:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                accumulate_bin(s_data);
            if (m_valid && m_ready)
                check_scan_report(m_data);
        end
        results_pending = expected_scan_reports.size();
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Testbench top: clock, reset, bin stimulus, register settings and the verdict.
module testbench;
    import pacd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRESSURE_HOLD  = 120;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BINS     = 140;
    localparam int FINAL_BINS     = 150;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;

    int          mismatch_count;
    int          results_checked;
    int          results_pending;
    int          quiet_cycles = 0;
    int          bins_sent = 0;
    int          scans_sent = 0;
    int          settings_used = 0;
    bit          sender_idle_en = 1'b1;
    bit          receiver_idle_en = 1'b1;
    bit          hold_off_req = 1'b0;
    bit          hold_off_done = 1'b0;
    cfg_t        cur_cfg;
    logic [31:0] scan_clock;

    precip_area_category_detector_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    pacd_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .results_checked (results_checked),
        .results_pending (results_pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Report receiver: random stall bursts, one long hold-off on request
    initial begin
        int burst;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                repeat (PRESSURE_HOLD) @(negedge aclk);
                hold_off_done = 1'b1;
            end else if (receiver_idle_en && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 11);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one bin, hold it until accepted; returns on a falling edge
    task automatic send_bin(input logic [7:0] refl, input logic [9:0] rng,
                            input logic is_last, input logic [31:0] t);
        in_item_t item;
        item.reflectivity = refl;
        item.range_index  = rng;
        item.scan_end     = is_last;
        item.scan_time    = t;
        if (sender_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        bins_sent++;
        if (is_last)
            scans_sent++;
    endtask

    // Advance the volume clock: mostly forward steps, sometimes jumps, wraps or steps back
    task automatic advance_scan_clock();
        case ($urandom_range(0, 19))
            0:       scan_clock = $urandom();
            1:       scan_clock = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
            2:       scan_clock = scan_clock - $urandom_range(0, 600);
            default: scan_clock = scan_clock + $urandom_range(0, 1500);
        endcase
    endtask

    // One scan of random bins, closed by a scan-end bin
    task automatic send_scan(input int len);
        logic [7:0]  refl;
        logic [9:0]  rng;
        logic [31:0] t;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0:       refl = cur_cfg.missing_code;
                1:       refl = cur_cfg.z_threshold_scaled;
                2:       refl = cur_cfg.z_threshold_scaled - 8'd1;
                3, 4:    refl = 8'($urandom_range(0, 255));
                default: refl = 8'($urandom_range(cur_cfg.z_threshold_scaled, 255));
            endcase
            case ($urandom_range(0, 19))
                0:       rng = 10'($urandom_range(NUM_RANGE_BINS, 1023));
                1:       rng = 10'(NUM_RANGE_BINS - 1 + $urandom_range(0, 1));
                default: rng = 10'($urandom_range(0, NUM_RANGE_BINS - 1));
            endcase
            if (i == len - 1) begin
                advance_scan_clock();
                t = scan_clock;
            end else begin
                t = $urandom();
            end
            send_bin(refl, rng, i == len - 1, t);
        end
    endtask

    function automatic int random_scan_len();
        return ($urandom_range(0, 9) < 3) ? 1 : $urandom_range(2, 40);
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.z_threshold_scaled = $urandom_range(0, 1) ? 8'($urandom_range(2, 140))
                                                    : 8'($urandom_range(2, 255));
        c.missing_code = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255));
        c.area_threshold_km2 = ($urandom_range(0, 4) == 0) ? 17'($urandom_range(0, 100000))
                                                            : 17'($urandom_range(0, 400));
        c.bin_area_unit = $urandom_range(0, 1) ? 24'($urandom_range(0, 24'hFF_FFFF))
                                               : 24'($urandom_range(20000, 100000));
        c.auto_precip_mode = ($urandom_range(0, 3) != 0);
        c.clear_air_hold_minutes = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 1440))
                                                                : 11'($urandom_range(0, 60));
        return c;
    endfunction

    // Write every register, one per cycle, while the block is idle
    task automatic apply_settings(input cfg_t c);
        for (int i = CFG_Z_THRESHOLD; i <= CFG_HOLD_MINUTES; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            case (cfg_index_t'(i))
                CFG_Z_THRESHOLD:   cfg_wdata <= CFG_DATA_W'(c.z_threshold_scaled);
                CFG_MISSING_CODE:  cfg_wdata <= CFG_DATA_W'(c.missing_code);
                CFG_AREA_THRESH:   cfg_wdata <= CFG_DATA_W'(c.area_threshold_km2);
                CFG_BIN_AREA_UNIT: cfg_wdata <= c.bin_area_unit;
                CFG_AUTO_PRECIP:   cfg_wdata <= CFG_DATA_W'(c.auto_precip_mode);
                CFG_HOLD_MINUTES:  cfg_wdata <= CFG_DATA_W'(c.clear_air_hold_minutes);
                default:           cfg_wdata <= '0;
            endcase
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        cur_cfg = c;
        settings_used++;
    endtask

    // Drop valid, wait for every report, then let the pipeline drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (results_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_random_phase(input int target);
        int start;
        start = bins_sent;
        apply_settings(random_settings());
        while (bins_sent - start < target)
            send_scan(random_scan_len());
        wait_idle();
    endtask

    initial begin
        cfg_t c;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        scan_clock = 32'd1000;
        cur_cfg.z_threshold_scaled     = Z_THRESHOLD_RST;
        cur_cfg.missing_code           = MISSING_CODE_RST;
        cur_cfg.area_threshold_km2     = AREA_THRESH_RST;
        cur_cfg.bin_area_unit          = BIN_AREA_UNIT_RST;
        cur_cfg.auto_precip_mode       = AUTO_PRECIP_RST;
        cur_cfg.clear_air_hold_minutes = HOLD_MINUTES_RST;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset defaults: count edges, missing code, beyond-table bins, time stepping back
        send_bin(8'd255, 10'd0, 1'b0, 32'd0);
        send_bin(8'd0, 10'd229, 1'b0, 32'hFFFF_FFFF);
        send_bin(Z_THRESHOLD_RST, 10'd229, 1'b0, 32'd0);
        send_bin(Z_THRESHOLD_RST - 8'd1, 10'd100, 1'b0, 32'd0);
        send_bin(8'd255, 10'd230, 1'b0, 32'd0);
        send_bin(8'd255, 10'd1023, 1'b0, 32'd0);
        send_bin(8'd200, 10'd50, 1'b1, 32'd1000);
        send_bin(8'd255, 10'd229, 1'b1, 32'd0);
        wait_idle();

        // Lowest threshold, top missing code, zero area threshold, top unit, longest hold
        c.z_threshold_scaled     = 8'd2;
        c.missing_code           = 8'd255;
        c.area_threshold_km2     = 17'd0;
        c.bin_area_unit          = 24'hFF_FFFF;
        c.auto_precip_mode       = 1'b1;
        c.clear_air_hold_minutes = 11'd1440;
        apply_settings(c);
        send_bin(8'd255, 10'd7, 1'b0, 32'd0);
        send_bin(8'd2, 10'd0, 1'b0, 32'd0);
        send_bin(8'd1, 10'd3, 1'b0, 32'd0);
        send_bin(8'd0, 10'd1023, 1'b1, 32'hFFFF_FFFF);
        send_bin(8'd255, 10'd229, 1'b1, 32'hFFFF_FF00);
        wait_idle();

        // Top threshold, top area threshold, zero unit, zero hold: hold restart near wrap
        c.z_threshold_scaled     = 8'd255;
        c.missing_code           = 8'd0;
        c.area_threshold_km2     = 17'd100000;
        c.bin_area_unit          = 24'd0;
        c.auto_precip_mode       = 1'b1;
        c.clear_air_hold_minutes = 11'd0;
        apply_settings(c);
        send_bin(8'd255, 10'd229, 1'b1, 32'hFFFF_FFF0);
        send_bin(8'd255, 10'd0, 1'b1, 32'd5);
        wait_idle();

        // Auto precip mode off
        c.z_threshold_scaled     = Z_THRESHOLD_RST;
        c.area_threshold_km2     = 17'd0;
        c.bin_area_unit          = BIN_AREA_UNIT_RST;
        c.auto_precip_mode       = 1'b0;
        c.clear_air_hold_minutes = HOLD_MINUTES_RST;
        apply_settings(c);
        send_bin(8'd9, 10'd229, 1'b1, 32'd7200);
        wait_idle();

        // Random settings and scans; one phase starts with a long receiver hold-off
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES / 2) begin
                apply_settings(random_settings());
                sender_idle_en = 1'b0;
                hold_off_req   = 1'b1;
                repeat (40) send_scan($urandom_range(1, 2));
                wait_idle();
                sender_idle_en = 1'b1;
            end
            run_random_phase(PHASE_BINS);
        end

        // Closing stretch at full rate on both sides
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        run_random_phase(FINAL_BINS);

        $display("Covered %0d bins in %0d scans over %0d register settings, with a %0d-cycle",
                 bins_sent, scans_sent, settings_used, PRESSURE_HOLD);
        $display("report hold-off; %0d reports checked, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
